@@ rtl/core/bed_pkg.sv @@
// ----------------------------------------------------------------------------
// Backslash escape decoder package
// Shared types, character constants and the simple escape table.
// ----------------------------------------------------------------------------
package bed_pkg;

  localparam int BYTE_W   = 8;
  localparam int OCT_BASE = 8;
  localparam int OCT_BITS = $clog2(OCT_BASE);

  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_C      = 8'h63;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_SEVEN  = 8'h37;

  // Parser modes. The unused code behaves as normal.
  localparam int MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ESC    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OCT    = 2'd2;

  localparam int DIG_W = 2;
  localparam logic [DIG_W-1:0] OCT_MAX_DIGITS = 2'd3;

  // Result queue geometry.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = FIFO_AW + 1;
  localparam int NRES_W     = 2;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              valid;
    logic              last;
    logic              stopped;
  } res_t;

  typedef struct packed {
    logic              hit;
    logic [BYTE_W-1:0] code;
  } esc_t;

  function automatic esc_t simple_escape(input logic [BYTE_W-1:0] b);
    esc_t e;
    e.hit = 1'b1;
    unique case (b)
      8'h61:     e.code = 8'd7;
      8'h62:     e.code = 8'd8;
      8'h66:     e.code = 8'd12;
      8'h6E:     e.code = 8'd10;
      8'h72:     e.code = 8'd13;
      8'h74:     e.code = 8'd9;
      8'h76:     e.code = 8'd11;
      CH_BSLASH: e.code = CH_BSLASH;
      default: begin
        e.hit  = 1'b0;
        e.code = '0;
      end
    endcase
    return e;
  endfunction

  function automatic logic is_octal(input logic [BYTE_W-1:0] b);
    return (b >= CH_ZERO) && (b <= CH_SEVEN);
  endfunction

endpackage

@@ rtl/core/bed_in_stage.sv @@
// ----------------------------------------------------------------------------
// Input stage
// Registers one request from the input channel until the decoder takes it.
// ----------------------------------------------------------------------------
module bed_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,
  input  logic          in_tlast,
  input  logic          take,
  output logic          item_valid,
  output bed_pkg::item_t item
);
  import bed_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_tready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.data <= in_tdata;
      item_r.last <= in_tlast;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

@@ rtl/core/bed_decode.sv @@
// ----------------------------------------------------------------------------
// Escape decoder
// Parser state and the per-byte decode that yields zero to two results.
// ----------------------------------------------------------------------------
module bed_decode (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      item_valid,
  input  bed_pkg::item_t            item,
  input  logic                      stop_on_c,
  input  logic [bed_pkg::CNT_W-1:0] fifo_count,
  output logic                      take,
  output logic [bed_pkg::NRES_W-1:0] push_n,
  output bed_pkg::res_t             res0,
  output bed_pkg::res_t             res1
);
  import bed_pkg::*;

  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [BYTE_W-1:0] oval_r, oval_nxt;
  logic [DIG_W-1:0]  odig_r, odig_nxt;
  logic              stop_r, stop_nxt;

  logic [NRES_W-1:0] n;
  res_t              r0, r1;
  esc_t              esc;
  logic [BYTE_W-1:0] b;
  logic              last;
  logic [BYTE_W-1:0] digit;
  logic [BYTE_W-1:0] oct_acc;
  logic [DIG_W-1:0]  dig_inc;

  assign b       = item.data;
  assign last    = item.last;
  assign esc     = simple_escape(b);
  assign digit   = b - CH_ZERO;
  assign oct_acc = {oval_r[BYTE_W-OCT_BITS-1:0], digit[OCT_BITS-1:0]};
  assign dig_inc = odig_r + 1'b1;

  always_comb begin
    n        = '0;
    r0       = '0;
    r1       = '0;
    mode_nxt = mode_r;
    oval_nxt = oval_r;
    odig_nxt = odig_r;
    stop_nxt = stop_r;

    if (stop_r) begin
      // Everything is swallowed until the end of the string.
      if (last) begin
        r0 = '{data: '0, valid: 1'b0, last: 1'b1, stopped: 1'b1};
        n  = 2'd1;
      end
    end else if (mode_r == MODE_ESC) begin
      mode_nxt = MODE_NORMAL;
      if (esc.hit) begin
        r0 = '{data: esc.code, valid: 1'b1, last: last, stopped: 1'b0};
        n  = 2'd1;
      end else if (b == CH_C) begin
        if (stop_on_c) begin
          stop_nxt = 1'b1;
          if (last) begin
            r0 = '{data: '0, valid: 1'b0, last: 1'b1, stopped: 1'b1};
            n  = 2'd1;
          end
        end else begin
          r0 = '{data: CH_C, valid: 1'b1, last: last, stopped: 1'b0};
          n  = 2'd1;
        end
      end else if (is_octal(b)) begin
        oval_nxt = digit;
        odig_nxt = 2'd1;
        if (last) begin
          r0 = '{data: digit, valid: 1'b1, last: 1'b1, stopped: 1'b0};
          n  = 2'd1;
        end else begin
          mode_nxt = MODE_OCT;
        end
      end else begin
        // Unknown escape: the backslash and the character both pass.
        r0 = '{data: CH_BSLASH, valid: 1'b1, last: 1'b0, stopped: 1'b0};
        r1 = '{data: b, valid: 1'b1, last: last, stopped: 1'b0};
        n  = 2'd2;
      end
    end else if (mode_r == MODE_OCT) begin
      if (is_octal(b)) begin
        if (dig_inc == OCT_MAX_DIGITS || last) begin
          r0       = '{data: oct_acc, valid: 1'b1, last: last, stopped: 1'b0};
          n        = 2'd1;
          mode_nxt = MODE_NORMAL;
          oval_nxt = '0;
          odig_nxt = '0;
        end else begin
          oval_nxt = oct_acc;
          odig_nxt = dig_inc;
        end
      end else begin
        // The pending byte goes out first, then the character is handled.
        r0       = '{data: oval_r, valid: 1'b1, last: 1'b0, stopped: 1'b0};
        n        = 2'd1;
        mode_nxt = MODE_NORMAL;
        oval_nxt = '0;
        odig_nxt = '0;
        if (b == CH_BSLASH && !last) begin
          mode_nxt = MODE_ESC;
        end else begin
          r1 = '{data: b, valid: 1'b1, last: last, stopped: 1'b0};
          n  = 2'd2;
        end
      end
    end else begin
      mode_nxt = MODE_NORMAL;
      if (b == CH_BSLASH && !last) begin
        mode_nxt = MODE_ESC;
      end else begin
        r0 = '{data: b, valid: 1'b1, last: last, stopped: 1'b0};
        n  = 2'd1;
      end
    end

    if (last) begin
      mode_nxt = MODE_NORMAL;
      oval_nxt = '0;
      odig_nxt = '0;
      stop_nxt = 1'b0;
    end
  end

  // Only the registered fill level is used, so out_tready never reaches in_tready.
  assign take = item_valid &&
                (({1'b0, fifo_count} + (CNT_W+1)'(n)) <= (CNT_W+1)'(FIFO_DEPTH));

  assign push_n = take ? n : '0;
  assign res0   = r0;
  assign res1   = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      oval_r <= '0;
      odig_r <= '0;
      stop_r <= 1'b0;
    end else if (take) begin
      mode_r <= mode_nxt;
      oval_r <= oval_nxt;
      odig_r <= odig_nxt;
      stop_r <= stop_nxt;
    end
  end

endmodule

@@ rtl/core/bed_out_fifo.sv @@
// ----------------------------------------------------------------------------
// Result queue
// Small queue that takes up to two results a cycle and drives the output.
// ----------------------------------------------------------------------------
module bed_out_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [bed_pkg::NRES_W-1:0] push_n,
  input  bed_pkg::res_t              res0,
  input  bed_pkg::res_t              res1,
  output logic [bed_pkg::CNT_W-1:0]  count,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output bed_pkg::res_t              head
);
  import bed_pkg::*;

  res_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               pop;
  logic [FIFO_AW-1:0] wr_ptr_p1;

  assign pop        = out_tvalid && out_tready;
  assign wr_ptr_p1  = wr_ptr_r + 1'b1;
  assign wr_ptr_nxt = wr_ptr_r + FIFO_AW'(push_n);
  assign rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop);
  assign count_nxt  = count_r + CNT_W'(push_n) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != '0) begin
      mem_r[wr_ptr_r] <= res0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr_p1] <= res1;
    end
  end

  assign count      = count_r;
  assign out_tvalid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

endmodule

@@ rtl/core/backslash_escape_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// Backslash escape decoder
// Decodes C-style backslash escapes in a byte stream.
//
//   Channel  Dir  Requests carry
//   in_      in   tdata = character, tlast = end of string
//   out_     out  tdata = decoded byte, tuser = {stopped, byte_valid},
//                 tlast = final result of the string
//   cfg_     in   wr_data = stop on backslash-c
//
// Each byte passes the input register, is decoded combinationally and its zero,
// one or two results land in a four-entry result queue, which drives the
// single output port. The decoder takes the next byte while the queue has
// room for all of its results.
// Reset is synchronous; afterwards stop on backslash-c is enabled.
// A stalled output fills the queue and then holds off the input.
// ----------------------------------------------------------------------------
module backslash_escape_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [0] byte_valid, [1] stopped
  output logic       out_tlast,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);
  import bed_pkg::*;

  logic              stop_on_c_r;
  logic              item_valid;
  item_t             item;
  logic              take;
  logic [NRES_W-1:0] push_n;
  res_t              res0, res1, head;
  logic [CNT_W-1:0]  fifo_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_on_c_r <= 1'b1;
    end else if (cfg_wr_en) begin
      stop_on_c_r <= cfg_wr_data;
    end
  end

  bed_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  bed_decode u_dec (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .stop_on_c  (stop_on_c_r),
    .fifo_count (fifo_count),
    .take       (take),
    .push_n     (push_n),
    .res0       (res0),
    .res1       (res1)
  );

  bed_out_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_n     (push_n),
    .res0       (res0),
    .res1       (res1),
    .count      (fifo_count),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .head       (head)
  );

  assign out_tdata = head.data;
  assign out_tuser = {head.stopped, head.valid};
  assign out_tlast = head.last;

endmodule

@@ rtl/core/bed_checker.sv @@
// ----------------------------------------------------------------------------
// Decoder port checker
// Checks the result channel of the decoder over time, bound to the top level.
// ----------------------------------------------------------------------------
module bed_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser,
  input logic       out_tlast
);

  // A result waiting on the output must not change.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // The queue comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  // A bare end marker only follows a stop and always closes the string.
  a_bare_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tuser[1] && out_tlast && (out_tdata == 8'h00))
    else $error("malformed bare end marker");

  // The stopped flag appears only on the bare end marker.
  a_stopped_bare: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> !out_tuser[0])
    else $error("stopped flag on a data result");

endmodule

bind backslash_escape_decoder_unit bed_checker u_bed_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
